### sv/fbsc_pkg.sv
`default_nettype none
package fbsc_pkg;

	// Block framing bytes
	localparam logic [7:0] TYPE_SHORT = 8'h08;
	localparam logic [7:0] TYPE_LONG  = 8'h88;
	localparam int unsigned LEN_EXT_BIT = 7;

	// Block lengths
	localparam logic [8:0] FULL_LEN     = 9'h1f8;
	localparam logic [8:0] BOOT_LEN     = 9'd4;
	localparam logic [8:0] MIN_DATA_LEN = 9'd7;

	// Payload positions of the little-endian size field
	localparam logic [8:0] SIZE_LO_POS = 9'd4;
	localparam logic [8:0] SIZE_HI_POS = 9'd5;
	localparam logic [16:0] SIZE_OFFSET = 17'd6;

	// Index of the last trailer byte
	localparam logic [1:0] TRAIL_LAST = 2'd2;

	// Block phase, one-hot
	typedef enum logic [3:0] {
		PH_TYPE    = 4'b0001,
		PH_LEN     = 4'b0010,
		PH_PAYLOAD = 4'b0100,
		PH_TRAIL   = 4'b1000
	} phase_t;

	// Expected trailer byte for a block kind and trailer index
	function automatic logic [7:0] trailer_byte(input logic is_boot, input logic [1:0] idx);
		logic [7:0] r;
		r = 8'h00;
		if (is_boot) begin
			case (idx)
				2'd0:    r = 8'h00;
				2'd1:    r = 8'h01;
				default: r = 8'h14;
			endcase
		end else begin
			case (idx)
				2'd0:    r = 8'h40;
				2'd1:    r = 8'h01;
				default: r = 8'h12;
			endcase
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### sv/firmware_block_stream_checker.sv
// Firmware block stream checker.
// Input channel (in_valid/in_ready): one image byte per transfer on data_byte,
// with end_of_image high on the final byte of the image.
// Output channel (out_valid/out_ready): one transfer per image, carrying
// image_valid, produced only for the byte that carries end_of_image.
// Each accepted byte is held in an input register; when it moves on, the
// framing state is updated and, on the final byte, the verdict is written to
// the result register, which drives out_valid.
// One byte is taken every cycle; the only limit is the single result register,
// which holds the next final byte back while a verdict still waits to be taken.
// After a verdict is produced all framing state returns to its reset value,
// so the next byte starts a new image.
// Reset (arst_n low) empties both registers and clears the framing state.
// While out_ready is low, non-final bytes keep flowing; a final byte waits in
// the input register and in_ready drops until the result has been taken.
`default_nettype none
module firmware_block_stream_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_image,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            image_valid
);

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eoi_s1;

	// Framing state
	fbsc_pkg::phase_t phase_q;
	logic [8:0] pos_q;
	logic       is_boot_q;
	logic [8:0] len_q;
	logic [7:0] size_lo_q;
	logic       boot_seen_q;
	logic       last_seen_q;
	logic       failed_q;

	// Result register
	logic out_valid_q;
	logic image_valid_q;

	// Next-state values
	fbsc_pkg::phase_t phase_d;
	logic [8:0]  pos_d;
	logic        is_boot_d;
	logic [8:0]  len_d;
	logic [7:0]  size_lo_d;
	logic        boot_seen_d;
	logic        last_seen_d;
	logic        failed_d;
	logic [8:0]  len_full;
	logic [8:0]  pos_inc;
	logic [16:0] size_plus;
	logic [1:0]  trail_idx;
	logic        advance;

	// Stage 1 moves on unless it holds a final byte and the result is still pending
	assign advance  = valid_s1 && (!eoi_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign len_full  = {len_q[8], byte_s1};
	assign pos_inc   = pos_q + 9'd1;
	assign size_plus = {1'b0, byte_s1, size_lo_q} + fbsc_pkg::SIZE_OFFSET;
	assign trail_idx = (pos_q < 9'd3) ? pos_q[1:0] : fbsc_pkg::TRAIL_LAST;

	// Framing update for the byte in stage 1
	always_comb begin
		phase_d     = phase_q;
		pos_d       = pos_q;
		is_boot_d   = is_boot_q;
		len_d       = len_q;
		size_lo_d   = size_lo_q;
		boot_seen_d = boot_seen_q;
		last_seen_d = last_seen_q;
		failed_d    = failed_q;
		if (!failed_q) begin
			case (phase_q)
				fbsc_pkg::PH_TYPE: begin
					if (byte_s1 != fbsc_pkg::TYPE_SHORT && byte_s1 != fbsc_pkg::TYPE_LONG) begin
						failed_d = 1'b1;
					end else begin
						len_d   = {byte_s1[fbsc_pkg::LEN_EXT_BIT], 8'h00};
						phase_d = fbsc_pkg::PH_LEN;
					end
				end
				fbsc_pkg::PH_LEN: begin
					len_d   = len_full;
					pos_d   = 9'd0;
					phase_d = fbsc_pkg::PH_PAYLOAD;
					if (len_full >= fbsc_pkg::MIN_DATA_LEN && len_full <= fbsc_pkg::FULL_LEN) begin
						// data block: none after boot or last data block
						if (boot_seen_q || last_seen_q) begin
							failed_d = 1'b1;
						end
						if (len_full < fbsc_pkg::FULL_LEN) begin
							last_seen_d = 1'b1;
						end
						is_boot_d = 1'b0;
					end else if (len_full == fbsc_pkg::BOOT_LEN) begin
						if (boot_seen_q) begin
							failed_d = 1'b1;
						end
						boot_seen_d = 1'b1;
						is_boot_d   = 1'b1;
					end else begin
						failed_d = 1'b1;
					end
				end
				fbsc_pkg::PH_PAYLOAD: begin
					if (!is_boot_q && pos_q == fbsc_pkg::SIZE_LO_POS) begin
						size_lo_d = byte_s1;
					end
					if (!is_boot_q && pos_q == fbsc_pkg::SIZE_HI_POS
							&& {8'h00, len_q} != size_plus) begin
						failed_d = 1'b1;
					end
					pos_d = pos_inc;
					if (pos_inc == len_q) begin
						pos_d   = 9'd0;
						phase_d = fbsc_pkg::PH_TRAIL;
					end
				end
				fbsc_pkg::PH_TRAIL: begin
					if (byte_s1 != fbsc_pkg::trailer_byte(is_boot_q, trail_idx)) begin
						failed_d = 1'b1;
					end
					pos_d = pos_inc;
					if (trail_idx == fbsc_pkg::TRAIL_LAST) begin
						pos_d     = 9'd0;
						is_boot_d = 1'b0;
						phase_d   = fbsc_pkg::PH_TYPE;
					end
				end
				default: begin
					failed_d = 1'b1;
				end
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			eoi_s1  <= end_of_image;
		end
	end

	// Framing state; the final byte returns it to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= fbsc_pkg::PH_TYPE;
			pos_q       <= 9'd0;
			is_boot_q   <= 1'b0;
			len_q       <= 9'd0;
			size_lo_q   <= 8'h00;
			boot_seen_q <= 1'b0;
			last_seen_q <= 1'b0;
			failed_q    <= 1'b0;
		end else if (advance) begin
			if (eoi_s1) begin
				phase_q     <= fbsc_pkg::PH_TYPE;
				pos_q       <= 9'd0;
				is_boot_q   <= 1'b0;
				len_q       <= 9'd0;
				size_lo_q   <= 8'h00;
				boot_seen_q <= 1'b0;
				last_seen_q <= 1'b0;
				failed_q    <= 1'b0;
			end else begin
				phase_q     <= phase_d;
				pos_q       <= pos_d;
				is_boot_q   <= is_boot_d;
				len_q       <= len_d;
				size_lo_q   <= size_lo_d;
				boot_seen_q <= boot_seen_d;
				last_seen_q <= last_seen_d;
				failed_q    <= failed_d;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && eoi_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && eoi_s1) begin
			image_valid_q <= !failed_d && (phase_d == fbsc_pkg::PH_TYPE);
		end
	end

	assign out_valid   = out_valid_q;
	assign image_valid = image_valid_q;

endmodule
`default_nettype wire
